// ----- src/insort_pkg.sv -----
// Package for the insertion sorter: sizes, cell control struct.
// No dependencies; used by every module in src.
package insort_pkg;

    localparam int DEPTH     = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 11;
    localparam int GRP_SIZE  = 8;
    localparam int GRP_N     = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_SUM_W = $clog2(GRP_SIZE + 1);
    localparam int SUM_W     = $clog2(GRP_N * GRP_SIZE + 1);

    // Control broadcast to every cell in the chain.
    typedef struct packed {
        logic ins;  // insert the broadcast value
        logic pop;  // shift the chain down by one place
    } t_cell_ctl;

endpackage

// ----- src/insort_cell.sv -----
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on insort_pkg.
module insort_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  insort_pkg::t_cell_ctl        i_ctl,
    input  logic [insort_pkg::VAL_W-1:0] i_value,
    input  logic [insort_pkg::VAL_W-1:0] i_prev_val,
    input  logic                         i_prev_gt,
    input  logic                         i_prev_valid,
    input  logic [insort_pkg::VAL_W-1:0] i_next_val,
    input  logic                         i_next_valid,
    output logic [insort_pkg::VAL_W-1:0] o_val,
    output logic                         o_valid,
    output logic                         o_gt,
    output logic                         o_move
);
    import insort_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic             r_valid;
    logic [VAL_W-1:0] n_val;
    logic             n_valid;
    logic             w_cmp;

    assign w_cmp  = $signed(r_val) > $signed(i_value);
    // an empty cell counts as greater so the first free cell takes the value
    assign o_gt   = !r_valid || w_cmp;
    assign o_move = r_valid && w_cmp;
    assign o_val  = r_val;
    assign o_valid = r_valid;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctl.pop) begin
            n_val   = i_next_val;
            n_valid = i_next_valid;
        end else if (i_ctl.ins && o_gt) begin
            n_val   = i_prev_gt ? i_prev_val : i_value;
            n_valid = r_valid || i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ----- src/insort_count.sv -----
// Move counter: registered popcount tree over the per-cell move flags,
// accumulated into the set total. Depends on insort_pkg.
module insort_count (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [insort_pkg::DEPTH-1:0] i_move,
    input  logic                         i_clear,
    output logic [insort_pkg::CNT_W-1:0] o_total
);
    import insort_pkg::*;

    logic [GRP_N*GRP_SIZE-1:0] r_mv;
    logic [GRP_SUM_W-1:0]      r_grp [GRP_N];
    logic [CNT_W-1:0]          r_total;
    logic [GRP_SUM_W-1:0]      n_grp [GRP_N];
    logic [SUM_W-1:0]          n_sum;

    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GRP_SIZE; b++) begin
                n_grp[g] = n_grp[g] + GRP_SUM_W'(r_mv[g*GRP_SIZE+b]);
            end
        end
        n_sum = '0;
        for (int g = 0; g < GRP_N; g++) begin
            n_sum = n_sum + SUM_W'(r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv    <= '0;
            r_total <= '0;
            for (int g = 0; g < GRP_N; g++) begin
                r_grp[g] <= '0;
            end
        end else begin
            r_mv <= (GRP_N*GRP_SIZE)'(i_move);
            for (int g = 0; g < GRP_N; g++) begin
                r_grp[g] <= n_grp[g];
            end
            if (i_clear) begin
                r_total <= '0;
            end else begin
                r_total <= r_total + CNT_W'(n_sum);
            end
        end
    end

    assign o_total = r_total;

endmodule

// ----- src/insertion_sorter_core.sv -----
// Top level of the insertion sorter: cell chain, move counter, control.
// Depends on insort_pkg, insort_cell, insort_count.
//
// channel  dir  tdata                  tlast       tuser
// s_axis   in   [31:0] value           last        -
// m_axis   out  [31:0] sorted_value    end_of_set  [10:0] shift_count
//
// One value is inserted per cycle; every cell compares against the broadcast
// value in parallel and shifts up in the same cycle. After the item marked
// last, the move-count tree is drained, then the set leaves one value per
// cycle from cell 0 while m_axis_tready is high, as the chain shifts down.
// Input is not taken while a set is drained or emitted. A value arriving
// with the chain full is dropped. Reset empties the chain and the counter.
module insertion_sorter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,
    output logic [10:0] m_axis_tuser    // [10:0] shift_count
);
    import insort_pkg::*;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic             r_drain;
    logic             n_drain;

    logic [VAL_W-1:0] w_val   [DEPTH];
    logic             w_valid [DEPTH];
    logic             w_gt    [DEPTH];
    logic [DEPTH-1:0] w_move;
    t_cell_ctl        w_ctl;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_full;
    logic             w_end;
    logic [CNT_W-1:0] w_total;

    assign s_axis_tready = (r_state == S_LOAD);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_full    = w_valid[DEPTH-1];
    assign w_end     = w_valid[0] && !w_valid[1];
    assign m_axis_tvalid = (r_state == S_EMIT) && w_valid[0];
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    assign w_ctl.ins = w_in_acc && !w_full;
    assign w_ctl.pop = w_out_acc;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VAL_W-1:0] w_pv;
            logic             w_pg;
            logic             w_pvld;
            logic [VAL_W-1:0] w_nv;
            logic             w_nvld;
            logic             w_mv;
            if (gi == 0) begin : g_first
                assign w_pv   = '0;
                assign w_pg   = 1'b0;
                assign w_pvld = 1'b1;
            end else begin : g_mid
                assign w_pv   = w_val[gi-1];
                assign w_pg   = w_gt[gi-1];
                assign w_pvld = w_valid[gi-1];
            end
            if (gi == DEPTH-1) begin : g_tail
                assign w_nv   = '0;
                assign w_nvld = 1'b0;
            end else begin : g_body
                assign w_nv   = w_val[gi+1];
                assign w_nvld = w_valid[gi+1];
            end
            insort_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_value      (s_axis_tdata),
                .i_prev_val   (w_pv),
                .i_prev_gt    (w_pg),
                .i_prev_valid (w_pvld),
                .i_next_val   (w_nv),
                .i_next_valid (w_nvld),
                .o_val        (w_val[gi]),
                .o_valid      (w_valid[gi]),
                .o_gt         (w_gt[gi]),
                .o_move       (w_mv)
            );
            assign w_move[gi] = w_mv && w_ctl.ins;
        end
    endgenerate

    insort_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (w_move),
        .i_clear (w_out_acc && w_end),
        .o_total (w_total)
    );

    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = S_DRAIN;
                    n_drain = 1'b0;
                end
            end
            S_DRAIN: begin
                // wait for the popcount tree to fold in the final insert
                if (r_drain) begin
                    n_state = S_EMIT;
                end
                n_drain = 1'b1;
            end
            S_EMIT: begin
                if (w_out_acc && w_end) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    assign m_axis_tdata = w_val[0];
    assign m_axis_tlast = w_end;
    assign m_axis_tuser = w_total;

endmodule
